/* rtl/obb_sat_pkg.sv */
// Shared constants and types for the oriented box overlap test.
package obb_sat_pkg;

  // Width of one axis component, signed with a sign and integer bit.
  localparam int unsigned AXIS_W = 18;

  // Width and reset value of the epsilon register.
  localparam int unsigned EPS_W = 8;
  localparam logic [EPS_W-1:0] EPS_RESET = 8'd1;

  // Digit width of the shared digit-serial multiplier.
  localparam int unsigned DIGIT_W = 16;

  // Axis number that loads nothing.
  localparam logic [1:0] AXIS_IDX_NONE = 2'd3;

  // Classification of one queued beat.
  typedef struct packed {
    logic store;
    logic run;
  } item_kind_t;

endpackage

/* rtl/obb_sat_front.sv */
// Input side: accepts beats, classifies them and buffers them in a two-entry queue.
module obb_sat_front #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  output logic                                   full_o,
  input  logic                                   box_select_i,
  input  logic [1:0]                             axis_index_i,
  input  logic signed [obb_sat_pkg::AXIS_W-1:0]  axis_x_i,
  input  logic signed [obb_sat_pkg::AXIS_W-1:0]  axis_y_i,
  input  logic signed [obb_sat_pkg::AXIS_W-1:0]  axis_z_i,
  input  logic signed [POS_WIDTH-1:0]            center_coord_i,
  input  logic [POS_WIDTH-2:0]                   half_extent_i,
  input  logic                                   last_i,
  output logic                                   q_valid_o,
  output obb_sat_pkg::item_kind_t                q_kind_o,
  output logic                                   q_box_o,
  output logic [1:0]                             q_idx_o,
  output logic signed [obb_sat_pkg::AXIS_W-1:0]  q_ax_o,
  output logic signed [obb_sat_pkg::AXIS_W-1:0]  q_ay_o,
  output logic signed [obb_sat_pkg::AXIS_W-1:0]  q_az_o,
  output logic signed [POS_WIDTH-1:0]            q_center_o,
  output logic [POS_WIDTH-2:0]                   q_extent_o,
  input  logic                                   q_take_i
);
  import obb_sat_pkg::*;

  item_kind_t                 kind_q   [2];
  logic                       box_q    [2];
  logic [1:0]                 idx_q    [2];
  logic signed [AXIS_W-1:0]   ax_q     [2];
  logic signed [AXIS_W-1:0]   ay_q     [2];
  logic signed [AXIS_W-1:0]   az_q     [2];
  logic signed [POS_WIDTH-1:0] center_q [2];
  logic [POS_WIDTH-2:0]       extent_q [2];

  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  item_kind_t kind_in;
  logic       accept, enq, deq;

  // A beat with no axis to load and no test to run has no effect and is dropped.
  assign kind_in.store = (axis_index_i != AXIS_IDX_NONE);
  assign kind_in.run   = last_i;
  assign full_o        = (cnt_q == 2'd2);
  assign accept        = push_i & ~full_o;
  assign enq           = accept & (kind_in.store | kind_in.run);
  assign q_valid_o     = (cnt_q != 2'd0);
  assign deq           = q_take_i & q_valid_o;

  always_comb begin
    wr_ptr_d = enq ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = deq ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      kind_q[wr_ptr_q]   <= kind_in;
      box_q[wr_ptr_q]    <= box_select_i;
      idx_q[wr_ptr_q]    <= axis_index_i;
      ax_q[wr_ptr_q]     <= axis_x_i;
      ay_q[wr_ptr_q]     <= axis_y_i;
      az_q[wr_ptr_q]     <= axis_z_i;
      center_q[wr_ptr_q] <= center_coord_i;
      extent_q[wr_ptr_q] <= half_extent_i;
    end
  end

  assign q_kind_o   = kind_q[rd_ptr_q];
  assign q_box_o    = box_q[rd_ptr_q];
  assign q_idx_o    = idx_q[rd_ptr_q];
  assign q_ax_o     = ax_q[rd_ptr_q];
  assign q_ay_o     = ay_q[rd_ptr_q];
  assign q_az_o     = az_q[rd_ptr_q];
  assign q_center_o = center_q[rd_ptr_q];
  assign q_extent_o = extent_q[rd_ptr_q];

endmodule

/* rtl/obb_sat_dmul.sv */
// Unsigned digit-serial multiplier, most significant digit of the second operand first.
module obb_sat_dmul #(
  parameter int unsigned A_W = 52,
  parameter int unsigned B_W = 38
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [A_W-1:0]       a_i,
  input  logic [B_W-1:0]       b_i,
  output logic                 done_o,
  output logic [A_W+((B_W+obb_sat_pkg::DIGIT_W-1)/obb_sat_pkg::DIGIT_W)*obb_sat_pkg::DIGIT_W-1:0]
                               prod_o
);
  import obb_sat_pkg::*;

  localparam int unsigned ND = (B_W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned BP = ND * DIGIT_W;
  localparam int unsigned PW = A_W + BP;
  localparam int unsigned CW = $clog2(ND + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [A_W-1:0] a_q;
  logic [BP-1:0]  b_q;
  logic [PW-1:0]  acc_q;
  logic [A_W+DIGIT_W-1:0] step;

  assign step = a_q * b_q[BP-1 -: DIGIT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ND);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= BP'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q << DIGIT_W) + PW'(step);
      b_q   <= b_q << DIGIT_W;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* rtl/obb_sat_back.sv */
// Execution side: box stores, test sequencer, shared multiplier and result slot.
module obb_sat_back #(
  parameter int unsigned POS_WIDTH     = 32,
  parameter int unsigned ROT_FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [obb_sat_pkg::EPS_W-1:0]          cfg_wdata_i,
  input  logic                                   q_valid_i,
  input  obb_sat_pkg::item_kind_t                q_kind_i,
  input  logic                                   q_box_i,
  input  logic [1:0]                             q_idx_i,
  input  logic signed [obb_sat_pkg::AXIS_W-1:0]  q_ax_i,
  input  logic signed [obb_sat_pkg::AXIS_W-1:0]  q_ay_i,
  input  logic signed [obb_sat_pkg::AXIS_W-1:0]  q_az_i,
  input  logic signed [POS_WIDTH-1:0]            q_center_i,
  input  logic [POS_WIDTH-2:0]                   q_extent_i,
  output logic                                   q_take_o,
  output logic                                   res_empty_o,
  input  logic                                   res_pop_i,
  output logic                                   res_overlap_o
);
  import obb_sat_pkg::*;

  localparam int unsigned F    = ROT_FRAC_BITS;
  localparam int unsigned TW   = POS_WIDTH + AXIS_W + 2;
  localparam int unsigned DVW  = POS_WIDTH + 1;
  localparam int unsigned RRW  = 2 * AXIS_W + 2;
  localparam int unsigned ARW  = ((2 * AXIS_W > F + EPS_W) ? 2 * AXIS_W : F + EPS_W) + 2;
  localparam int unsigned BVW  = ARW + 1;
  localparam int unsigned ACCW = POS_WIDTH + ARW + 3 * F + 4;
  localparam int unsigned ND   = (ARW + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned PW   = TW + ND * DIGIT_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIFF  = 6'b000010,
    ST_ISSUE = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_WB    = 6'b010000,
    ST_CMP   = 6'b100000
  } state_e;

  typedef enum logic [4:0] {
    PH_RR = 5'b00001,
    PH_T  = 5'b00010,
    PH_TA = 5'b00100,
    PH_TB = 5'b01000,
    PH_TC = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    SRC_A_AXA, SRC_A_D, SRC_A_T, SRC_A_EXA, SRC_A_EXB
  } a_src_e;

  typedef enum logic [2:0] {
    SRC_B_AXA, SRC_B_AXB, SRC_B_RR, SRC_B_AR, SRC_B_ONE
  } b_src_e;

  function automatic logic [1:0] inc3(input logic [1:0] v);
    inc3 = (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  // Stores and intermediate results.
  logic signed [AXIS_W-1:0]    axis_a_q [3][3];
  logic signed [AXIS_W-1:0]    axis_b_q [3][3];
  logic signed [POS_WIDTH-1:0] center_a_q [3];
  logic signed [POS_WIDTH-1:0] center_b_q [3];
  logic [POS_WIDTH-2:0]        ext_a_q [3];
  logic [POS_WIDTH-2:0]        ext_b_q [3];
  logic signed [DVW-1:0]       d_q [3];
  logic signed [TW-1:0]        t_q [3];
  logic signed [RRW-1:0]       rr_q [3][3];
  logic [ARW-1:0]              ar_q [3][3];

  logic [EPS_W-1:0] eps_q;
  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [1:0] p_q, p_d, q_q, q_d;
  logic [2:0] m_q, m_d;
  logic signed [ACCW-1:0] x_q, x_d, y_q, y_d;
  logic res_valid_q, res_valid_d, res_q, res_d;

  // Term descriptor.
  a_src_e a_sel;
  b_src_e b_sel;
  logic [1:0] a_idx, b_i, b_j, sh;
  logic to_y, sub, last_term;
  logic [1:0] i1, i2, j1, j2;

  logic signed [AXIS_W-1:0] axa_rd, axb_rd;
  logic signed [TW-1:0]  a_val, a_neg_val;
  logic signed [BVW-1:0] b_val, b_neg_val;
  logic [TW-1:0]  a_mag;
  logic [ARW-1:0] b_mag;
  logic a_neg, b_neg, term_neg;
  logic mul_start, mul_done;
  logic [PW-1:0] mul_prod;
  logic signed [ACCW-1:0] prod_ext, shv, target, acc_new;
  logic [ARW-1:0] eps_f, ar_new;
  logic sep, st_we;

  assign i1 = inc3(p_q);
  assign i2 = inc3(i1);
  assign j1 = inc3(q_q);
  assign j2 = inc3(j1);

  always_comb begin
    a_sel = SRC_A_T;
    b_sel = SRC_B_ONE;
    a_idx = p_q;
    b_i = p_q;
    b_j = q_q;
    sh = 2'd0;
    to_y = 1'b0;
    sub = 1'b0;
    last_term = 1'b0;
    unique case (phase_q)
      PH_RR: begin
        a_sel = SRC_A_AXA;
        b_sel = SRC_B_AXB;
        last_term = (m_q == 3'd2);
      end
      PH_T: begin
        a_sel = SRC_A_D;
        b_sel = SRC_B_AXA;
        last_term = (m_q == 3'd2);
      end
      PH_TA: begin
        case (m_q)
          3'd0: begin a_sel = SRC_A_T; sh = 2'd1; end
          3'd1: begin a_sel = SRC_A_EXA; to_y = 1'b1; sh = 2'd2; end
          3'd2: begin a_sel = SRC_A_EXB; a_idx = 2'd0; b_sel = SRC_B_AR; b_j = 2'd0; to_y = 1'b1; end
          3'd3: begin a_sel = SRC_A_EXB; a_idx = 2'd1; b_sel = SRC_B_AR; b_j = 2'd1; to_y = 1'b1; end
          default: begin
            a_sel = SRC_A_EXB; a_idx = 2'd2; b_sel = SRC_B_AR; b_j = 2'd2; to_y = 1'b1;
            last_term = 1'b1;
          end
        endcase
      end
      PH_TB: begin
        case (m_q)
          3'd0: begin a_sel = SRC_A_T; a_idx = 2'd0; b_sel = SRC_B_RR; b_i = 2'd0; end
          3'd1: begin a_sel = SRC_A_T; a_idx = 2'd1; b_sel = SRC_B_RR; b_i = 2'd1; end
          3'd2: begin a_sel = SRC_A_T; a_idx = 2'd2; b_sel = SRC_B_RR; b_i = 2'd2; end
          3'd3: begin
            a_sel = SRC_A_EXA; a_idx = 2'd0; b_sel = SRC_B_AR; b_i = 2'd0; to_y = 1'b1; sh = 2'd1;
          end
          3'd4: begin
            a_sel = SRC_A_EXA; a_idx = 2'd1; b_sel = SRC_B_AR; b_i = 2'd1; to_y = 1'b1; sh = 2'd1;
          end
          3'd5: begin
            a_sel = SRC_A_EXA; a_idx = 2'd2; b_sel = SRC_B_AR; b_i = 2'd2; to_y = 1'b1; sh = 2'd1;
          end
          default: begin
            a_sel = SRC_A_EXB; a_idx = q_q; to_y = 1'b1; sh = 2'd3; last_term = 1'b1;
          end
        endcase
      end
      PH_TC: begin
        case (m_q)
          3'd0: begin a_sel = SRC_A_T; a_idx = i2; b_sel = SRC_B_RR; b_i = i1; end
          3'd1: begin a_sel = SRC_A_T; a_idx = i1; b_sel = SRC_B_RR; b_i = i2; sub = 1'b1; end
          3'd2: begin
            a_sel = SRC_A_EXA; a_idx = i1; b_sel = SRC_B_AR; b_i = i2; to_y = 1'b1; sh = 2'd1;
          end
          3'd3: begin
            a_sel = SRC_A_EXA; a_idx = i2; b_sel = SRC_B_AR; b_i = i1; to_y = 1'b1; sh = 2'd1;
          end
          3'd4: begin
            a_sel = SRC_A_EXB; a_idx = j1; b_sel = SRC_B_AR; b_j = j2; to_y = 1'b1; sh = 2'd1;
          end
          default: begin
            a_sel = SRC_A_EXB; a_idx = j2; b_sel = SRC_B_AR; b_j = j1; to_y = 1'b1; sh = 2'd1;
            last_term = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Operand selection and magnitudes for the multiplier.
  assign axa_rd = axis_a_q[p_q][m_q[1:0]];
  assign axb_rd = axis_b_q[q_q][m_q[1:0]];

  always_comb begin
    case (a_sel)
      SRC_A_AXA: a_val = TW'(axa_rd);
      SRC_A_D:   a_val = TW'(d_q[m_q[1:0]]);
      SRC_A_T:   a_val = t_q[a_idx];
      SRC_A_EXA: a_val = TW'(ext_a_q[a_idx]);
      default:   a_val = TW'(ext_b_q[a_idx]);
    endcase
    case (b_sel)
      SRC_B_AXA: b_val = BVW'(axa_rd);
      SRC_B_AXB: b_val = BVW'(axb_rd);
      SRC_B_RR:  b_val = BVW'(rr_q[b_i][b_j]);
      SRC_B_AR:  b_val = BVW'(ar_q[b_i][b_j]);
      default:   b_val = BVW'(1'b1);
    endcase
  end

  assign a_neg     = a_val[TW-1];
  assign b_neg     = b_val[BVW-1];
  assign a_neg_val = -a_val;
  assign b_neg_val = -b_val;
  assign a_mag     = a_neg ? a_neg_val : a_val;
  assign b_mag     = b_neg ? b_neg_val[ARW-1:0] : b_val[ARW-1:0];
  assign term_neg  = a_neg ^ b_neg ^ sub;

  obb_sat_dmul #(
    .A_W (TW),
    .B_W (ARW)
  ) u_dmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (a_mag),
    .b_i     (b_mag),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Accumulate the signed, scaled product into the left or right side.
  always_comb begin
    prod_ext = ACCW'(mul_prod);
    case (sh)
      2'd0:    shv = prod_ext;
      2'd1:    shv = prod_ext << F;
      2'd2:    shv = prod_ext << (2 * F);
      default: shv = prod_ext << (3 * F);
    endcase
    target  = to_y ? y_q : x_q;
    acc_new = term_neg ? target - shv : target + shv;
  end

  assign eps_f  = ARW'(eps_q) << F;
  assign ar_new = x_q[ACCW-1] ? eps_f - x_q[ARW-1:0] : x_q[ARW-1:0] + eps_f;
  assign sep    = (x_q > y_q) || (x_q < -y_q);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    p_d         = p_q;
    q_d         = q_q;
    m_d         = m_q;
    x_d         = x_q;
    y_d         = y_q;
    res_valid_d = res_valid_q & ~res_pop_i;
    res_d       = res_q;
    mul_start   = 1'b0;
    q_take_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && (!q_kind_i.run || !res_valid_q)) begin
          q_take_o = 1'b1;
          if (q_kind_i.run) begin
            state_d = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        phase_d = PH_RR;
        p_d = 2'd0;
        q_d = 2'd0;
        m_d = 3'd0;
        x_d = '0;
        y_d = '0;
        state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        mul_start = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          if (to_y) begin
            y_d = acc_new;
          end else begin
            x_d = acc_new;
          end
          if (last_term) begin
            state_d = (phase_q == PH_RR || phase_q == PH_T) ? ST_WB : ST_CMP;
          end else begin
            m_d = m_q + 3'd1;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_WB: begin
        x_d = '0;
        m_d = 3'd0;
        state_d = ST_ISSUE;
        if (phase_q == PH_RR) begin
          if (q_q != 2'd2) begin
            q_d = q_q + 2'd1;
          end else begin
            q_d = 2'd0;
            if (p_q != 2'd2) begin
              p_d = p_q + 2'd1;
            end else begin
              p_d = 2'd0;
              phase_d = PH_T;
            end
          end
        end else begin
          if (p_q != 2'd2) begin
            p_d = p_q + 2'd1;
          end else begin
            p_d = 2'd0;
            phase_d = PH_TA;
          end
        end
      end
      ST_CMP: begin
        x_d = '0;
        y_d = '0;
        m_d = 3'd0;
        state_d = ST_ISSUE;
        if (sep) begin
          res_valid_d = 1'b1;
          res_d = 1'b0;
          state_d = ST_IDLE;
        end else begin
          unique case (phase_q)
            PH_TA: begin
              if (p_q != 2'd2) begin
                p_d = p_q + 2'd1;
              end else begin
                p_d = 2'd0;
                q_d = 2'd0;
                phase_d = PH_TB;
              end
            end
            PH_TB: begin
              if (q_q != 2'd2) begin
                q_d = q_q + 2'd1;
              end else begin
                q_d = 2'd0;
                p_d = 2'd0;
                phase_d = PH_TC;
              end
            end
            default: begin
              if (q_q != 2'd2) begin
                q_d = q_q + 2'd1;
              end else if (p_q != 2'd2) begin
                q_d = 2'd0;
                p_d = p_q + 2'd1;
              end else begin
                res_valid_d = 1'b1;
                res_d = 1'b1;
                state_d = ST_IDLE;
              end
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_RR;
      p_q         <= 2'd0;
      q_q         <= 2'd0;
      m_q         <= 3'd0;
      res_valid_q <= 1'b0;
      eps_q       <= EPS_RESET;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      p_q         <= p_d;
      q_q         <= q_d;
      m_q         <= m_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
    end
  end

  assign st_we = q_take_o & q_kind_i.store;

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    res_q <= res_d;
    if (st_we) begin
      if (!q_box_i) begin
        axis_a_q[q_idx_i][0] <= q_ax_i;
        axis_a_q[q_idx_i][1] <= q_ay_i;
        axis_a_q[q_idx_i][2] <= q_az_i;
        center_a_q[q_idx_i]  <= q_center_i;
        ext_a_q[q_idx_i]     <= q_extent_i;
      end else begin
        axis_b_q[q_idx_i][0] <= q_ax_i;
        axis_b_q[q_idx_i][1] <= q_ay_i;
        axis_b_q[q_idx_i][2] <= q_az_i;
        center_b_q[q_idx_i]  <= q_center_i;
        ext_b_q[q_idx_i]     <= q_extent_i;
      end
    end
    if (state_q == ST_DIFF) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k] <= DVW'(center_b_q[k]) - DVW'(center_a_q[k]);
      end
    end
    if (state_q == ST_WB) begin
      if (phase_q == PH_RR) begin
        rr_q[p_q][q_q] <= x_q[RRW-1:0];
        ar_q[p_q][q_q] <= ar_new;
      end else begin
        t_q[p_q] <= x_q[TW-1:0];
      end
    end
  end

  assign res_empty_o   = ~res_valid_q;
  assign res_overlap_o = res_q;

  a_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_MUL)
    else $error("multiplier finished outside the multiply state");

  a_no_done_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ISSUE |=> !mul_done)
    else $error("multiplier finished one cycle after start");

  a_slot_free_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIFF |-> !res_valid_q)
    else $error("test started while a result was still waiting");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_pop_i |=> res_valid_q)
    else $error("waiting result lost without pop");

  a_res_from_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == ST_CMP))
    else $error("result produced outside an axis comparison");

endmodule

/* rtl/obb_overlap_separating_axis.sv */
// Top level of the oriented box overlap test by separating axes.
//
// Usage: the input channel is a queue write port (push, full). Each beat loads
// one local axis of box A or box B: the world axis vector, the center
// component whose index equals the axis number, and the half extent. A beat
// with last set also runs the fifteen-axis test on the stored boxes and yields
// one result beat on the queue read port (empty, pop, overlap_o).
// Load beats are taken one per cycle through a two-entry queue while the back
// side is idle. A test runs on one shared digit-serial multiplier, which takes
// the 16-bit digits of the rotation operand (3 by default) most significant
// first. A full test is 126 products; a test that finds a separating axis
// early stops at that axis. While a test runs the back side takes no beats,
// so the input queue fills after two beats and full stays high until the test
// ends. The result waits in a one-entry slot; while it is not popped, loads
// keep flowing until a beat with last set reaches the head of the queue, the
// next test does not start, and push sees full once the input queue fills.
// Reset empties both queues and sets epsilon to one. The user must write epsilon
// through cfg_we_i and cfg_wdata_i only while idle; the block does not enforce it.
module obb_overlap_separating_axis #(
  parameter int unsigned POS_WIDTH     = 32,
  parameter int unsigned ROT_FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [obb_sat_pkg::EPS_W-1:0]          cfg_wdata_i,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   box_select_i,
  input  logic [1:0]                             axis_index_i,
  input  logic signed [obb_sat_pkg::AXIS_W-1:0]  axis_x_i,
  input  logic signed [obb_sat_pkg::AXIS_W-1:0]  axis_y_i,
  input  logic signed [obb_sat_pkg::AXIS_W-1:0]  axis_z_i,
  input  logic signed [POS_WIDTH-1:0]            center_coord_i,
  input  logic [POS_WIDTH-2:0]                   half_extent_i,
  input  logic                                   last_i,
  output logic                                   empty,
  input  logic                                   pop,
  output logic                                   overlap_o
);
  import obb_sat_pkg::*;

  // Queue between the front and the back.
  logic                        q_valid, q_take, q_box;
  item_kind_t                  q_kind;
  logic [1:0]                  q_idx;
  logic signed [AXIS_W-1:0]    q_ax, q_ay, q_az;
  logic signed [POS_WIDTH-1:0] q_center;
  logic [POS_WIDTH-2:0]        q_extent;

  obb_sat_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .box_select_i   (box_select_i),
    .axis_index_i   (axis_index_i),
    .axis_x_i       (axis_x_i),
    .axis_y_i       (axis_y_i),
    .axis_z_i       (axis_z_i),
    .center_coord_i (center_coord_i),
    .half_extent_i  (half_extent_i),
    .last_i         (last_i),
    .q_valid_o      (q_valid),
    .q_kind_o       (q_kind),
    .q_box_o        (q_box),
    .q_idx_o        (q_idx),
    .q_ax_o         (q_ax),
    .q_ay_o         (q_ay),
    .q_az_o         (q_az),
    .q_center_o     (q_center),
    .q_extent_o     (q_extent),
    .q_take_i       (q_take)
  );

  // The back side owns the stores, the test sequencer and the result slot.
  obb_sat_back #(
    .POS_WIDTH     (POS_WIDTH),
    .ROT_FRAC_BITS (ROT_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_kind_i      (q_kind),
    .q_box_i       (q_box),
    .q_idx_i       (q_idx),
    .q_ax_i        (q_ax),
    .q_ay_i        (q_ay),
    .q_az_i        (q_az),
    .q_center_i    (q_center),
    .q_extent_i    (q_extent),
    .q_take_o      (q_take),
    .res_empty_o   (empty),
    .res_pop_i     (pop),
    .res_overlap_o (overlap_o)
  );

endmodule
